// File: design/cfb_pkg.sv
package cfb_pkg;

  // Frame constants
  localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
  localparam logic [7:0] START_CODE_A   = 8'h00;
  localparam logic [7:0] START_CODE_B   = 8'hFF;
  localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
  localparam logic [7:0] MAX_COUNT      = 8'd254;
  localparam logic [7:0] DIR_RESET      = 8'd212;

  // Position of a word inside the frame sequence
  localparam int unsigned POS_W = 4;
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_PRE   = 4'd0;
  localparam pos_t POS_STA   = 4'd1;
  localparam pos_t POS_STB   = 4'd2;
  localparam pos_t POS_LEN   = 4'd3;
  localparam pos_t POS_LCS   = 4'd4;
  localparam pos_t POS_DIR   = 4'd5;
  localparam pos_t POS_DATA  = 4'd6;
  localparam pos_t POS_DCS   = 4'd7;
  localparam pos_t POS_POST  = 4'd8;

  // One accepted input byte, worked out and ready to emit
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] data;
    logic [7:0] len;
    logic [7:0] dir;
    logic [7:0] csum;
  } job_t;

  // Sequencer view handed to the output stage
  typedef struct packed {
    logic valid;
    pos_t pos;
    logic at_end;
  } seq_t;

endpackage

// File: design/command_frame_builder.sv
// command_frame_builder: wraps command bytes into information frames.
// Accepted bytes are registered in the job slot, and their words pass through the output register.
// Throughput: one output word per cycle while out_tready is high; an input byte yields 1, 3, 7
// or 9 words (middle, last, first, first-and-last), set by the output word sequencer.
// Reset (rst_n low, synchronous): no frame open, direction register = 0xD4,
// job slot and output register empty.
module command_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] byte_count
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,
  output logic        out_tuser   // [0] frame_end
);

  cfb_pkg::job_t job;
  cfb_pkg::seq_t seq;
  logic          adv;

  // Frame state, job slot and word sequencer
  cfb_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .job         (job),
    .seq         (seq)
  );

  // Word select and output register
  cfb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .seq        (seq),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: design/cfb_track.sv
module cfb_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                adv,
  output cfb_pkg::job_t       job,
  output cfb_pkg::seq_t       seq
);

  logic [7:0]    bytes_left_r, bytes_left_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    dir_r;
  logic          job_valid_r;
  cfb_pkg::pos_t pos_r;
  cfb_pkg::job_t job_r, job_nxt;
  cfb_pkg::pos_t pos_end;
  logic          frame_open;
  logic          accept;
  logic          done;
  logic [7:0]    data_in;
  logic [7:0]    count_raw;
  logic [7:0]    count;
  logic [7:0]    len;
  logic [7:0]    sum_new;

  assign data_in   = in_tdata[7:0];
  assign count_raw = in_tdata[15:8];

  // Clamp the count and work out frame header values
  always_comb begin
    priority if (count_raw == 8'd0) begin
      count = 8'd1;
    end else if (count_raw > cfb_pkg::MAX_COUNT) begin
      count = cfb_pkg::MAX_COUNT;
    end else begin
      count = count_raw;
    end
    len = count + 8'd1;
  end

  // Next frame state and the job for this byte
  assign frame_open = (bytes_left_r != 8'd0);
  always_comb begin
    if (frame_open) begin
      sum_new        = sum_r + data_in;
      bytes_left_nxt = bytes_left_r - 8'd1;
    end else begin
      sum_new        = dir_r + data_in;
      bytes_left_nxt = count - 8'd1;
    end
    sum_nxt       = (bytes_left_nxt == 8'd0) ? 8'd0 : sum_new;
    job_nxt.first = !frame_open;
    job_nxt.last  = (bytes_left_nxt == 8'd0);
    job_nxt.data  = data_in;
    job_nxt.len   = len;
    job_nxt.dir   = dir_r;
    job_nxt.csum  = 8'd0 - sum_new;
  end

  // Handshake: take a new byte when the job slot frees up
  assign pos_end   = job_r.last ? cfb_pkg::POS_POST : cfb_pkg::POS_DATA;
  assign done      = job_valid_r && adv && (pos_r == pos_end);
  assign in_tready = !job_valid_r || done;
  assign accept    = in_tvalid && in_tready;

  // Hold frame state, direction register and word position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
      sum_r        <= 8'd0;
      dir_r        <= cfb_pkg::DIR_RESET;
      job_valid_r  <= 1'b0;
      pos_r        <= cfb_pkg::POS_PRE;
    end else begin
      if (cfg_wr_en) begin
        dir_r <= cfg_wr_data;
      end
      if (accept) begin
        bytes_left_r <= bytes_left_nxt;
        sum_r        <= sum_nxt;
        job_valid_r  <= 1'b1;
        pos_r        <= frame_open ? cfb_pkg::POS_DATA : cfb_pkg::POS_PRE;
      end else if (done) begin
        job_valid_r  <= 1'b0;
      end else if (job_valid_r && adv) begin
        pos_r        <= pos_r + cfb_pkg::pos_t'(1);
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job        = job_r;
  assign seq.valid  = job_valid_r;
  assign seq.pos    = pos_r;
  assign seq.at_end = (pos_r == pos_end);

  // A loaded job always has work left
  a_job_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> job_valid_r)
    else $error("job slot empty after accept");

  // Position stays within the job's window
  a_pos_window: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (pos_r <= pos_end) && (job_r.first || pos_r >= cfb_pkg::POS_DATA))
    else $error("word position out of window");

  // Frame closes exactly when the last byte is taken
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept && job_nxt.last |=> (bytes_left_r == 8'd0) && (sum_r == 8'd0))
    else $error("frame state not cleared at close");

endmodule

// File: design/cfb_emit.sv
module cfb_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  cfb_pkg::job_t  job,
  input  cfb_pkg::seq_t  seq,
  output logic           adv,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);

  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r;
  logic       end_r;

  // Pick the word for the current position
  always_comb begin
    unique case (seq.pos)
      cfb_pkg::POS_PRE:  byte_nxt = cfb_pkg::PREAMBLE_BYTE;
      cfb_pkg::POS_STA:  byte_nxt = cfb_pkg::START_CODE_A;
      cfb_pkg::POS_STB:  byte_nxt = cfb_pkg::START_CODE_B;
      cfb_pkg::POS_LEN:  byte_nxt = job.len;
      cfb_pkg::POS_LCS:  byte_nxt = 8'd0 - job.len;
      cfb_pkg::POS_DIR:  byte_nxt = job.dir;
      cfb_pkg::POS_DATA: byte_nxt = job.data;
      cfb_pkg::POS_DCS:  byte_nxt = job.csum;
      cfb_pkg::POS_POST: byte_nxt = cfb_pkg::POSTAMBLE_BYTE;
      default:           byte_nxt = cfb_pkg::POSTAMBLE_BYTE;
    endcase
  end

  // Load the output register when it is empty or being drained
  assign adv = seq.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= byte_nxt;
      last_r <= seq.at_end;
      end_r  <= (seq.pos == cfb_pkg::POS_POST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = end_r;

  // Postamble always closes the run and is a zero word
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> last_r && (byte_r == cfb_pkg::POSTAMBLE_BYTE))
    else $error("frame end without run end");

  // No word is taken from an empty job slot
  a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> seq.valid && (seq.pos <= cfb_pkg::POS_POST))
    else $error("advance without a job");

endmodule

// File: dv/tb_command_frame_builder.sv
`timescale 1ns / 1ps

module tb_command_frame_builder;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int DIR_ROWS     = 14;
  localparam int PHASE_ITEMS  = 118;
  localparam int NUM_PHASES   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // One outgoing word as the checker sees it
  typedef struct packed {
    logic [7:0] fbyte;
    logic       run_last;
    logic       frame_end;
  } frame_word_t;

  // Directed row: n_typed != 0 means the frame bytes are spelled out below
  typedef struct packed {
    logic [7:0]      data;
    logic [7:0]      count;
    logic [3:0]      n_typed;
    logic [0:8][7:0] typed_bytes;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [7:0] data_byte, [15:8] byte_count
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] frame_byte
  logic        out_tlast;
  logic        out_tuser;          // [0] frame_end

  // Frame predictor state
  logic [7:0]  dir_reg  = cfb_pkg::DIR_RESET;
  logic [7:0]  left_cnt = 8'd0;
  logic [7:0]  sum_acc  = 8'd0;
  frame_word_t step_word [0:8];
  int          step_cnt;

  frame_word_t frame_words [$];
  frame_word_t got_word;
  frame_word_t want_word;

  int   err_cnt       = 0;
  int   cycle_cnt     = 0;
  int   gap_pct       = 0;
  int   stall_pct     = 0;
  int   hold_cnt      = 0;
  logic pressure_arm  = 1'b0;
  logic pressure_done = 1'b0;

  // Directed table; frames at reset direction 0xD4 are spelled out where obvious
  stim_row_t stim_tab [DIR_ROWS] = '{
    {8'h00, 8'h01, 4'd9, 72'h0000FF02FED4002C00},  // one-byte frame
    {8'hFF, 8'h00, 4'd9, 72'h0000FF02FED4FF2D00},  // zero count acts as one
    {8'hA5, 8'h02, 4'd0, 72'h0},
    {8'h5A, 8'h4D, 4'd0, 72'h0},                   // count ignored mid-frame
    {8'h7F, 8'h03, 4'd0, 72'h0},
    {8'h80, 8'hFF, 4'd0, 72'h0},
    {8'h01, 8'h00, 4'd0, 72'h0},
    {8'hFF, 8'hFF, 4'd7, 72'h0000FFFF01D4FF0000},  // count 255 clamps to 254
    {8'h00, 8'h00, 4'd1, 72'h0},
    {8'hFF, 8'h01, 4'd1, 72'hFF0000000000000000},
    {8'h12, 8'h00, 4'd0, 72'h0},
    {8'h34, 8'hFF, 4'd0, 72'h0},
    {8'h56, 8'h80, 4'd0, 72'h0},
    {8'hC3, 8'h7F, 4'd0, 72'h0}
  };

  command_frame_builder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void report_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void add_word(input logic [7:0] b, input logic fend);
    step_word[step_cnt] = {b, 1'b0, fend};
    step_cnt++;
  endfunction

  // Work out the frame words one accepted byte produces, and advance the frame state
  function automatic void predict_frame(input logic [7:0] data, input logic [7:0] count);
    logic [7:0] n;
    logic [7:0] len;
    step_cnt = 0;
    if (left_cnt == 8'd0) begin
      n = count;
      if (n == 8'd0) n = 8'd1;
      if (n > cfb_pkg::MAX_COUNT) n = cfb_pkg::MAX_COUNT;
      len = n + 8'd1;
      add_word(cfb_pkg::PREAMBLE_BYTE, 1'b0);
      add_word(cfb_pkg::START_CODE_A, 1'b0);
      add_word(cfb_pkg::START_CODE_B, 1'b0);
      add_word(len, 1'b0);
      add_word(8'd0 - len, 1'b0);
      add_word(dir_reg, 1'b0);
      add_word(data, 1'b0);
      sum_acc  = dir_reg + data;
      left_cnt = n - 8'd1;
    end else begin
      add_word(data, 1'b0);
      sum_acc  = sum_acc + data;
      left_cnt = left_cnt - 8'd1;
    end
    // Close the frame with checksum and postamble
    if (left_cnt == 8'd0) begin
      add_word(8'd0 - sum_acc, 1'b0);
      add_word(cfb_pkg::POSTAMBLE_BYTE, 1'b1);
      sum_acc = 8'd0;
    end
    step_word[step_cnt-1].run_last = 1'b1;
  endfunction

  // Offer one input word, wait for acceptance, queue its frame words
  task automatic send_word(input logic [7:0] data, input logic [7:0] count,
                           input logic [3:0] n_typed, input logic [0:8][7:0] typed);
    frame_word_t w;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {count, data};
    do @(posedge clk); while (!in_tready);
    predict_frame(data, count);
    for (int i = 0; i < step_cnt; i++) begin
      w = step_word[i];
      if (n_typed != 4'd0) w.fbyte = typed[i];
      frame_words.push_back(w);
    end
  endtask

  // Drain pending words, then load a new direction byte
  task automatic write_dir(input logic [7:0] value);
    in_tvalid <= 1'b0;
    while (frame_words.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dir_reg = value;
  endtask

  // Receive side: check accepted words, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_word = {out_tdata, out_tlast, out_tuser};
        if (frame_words.size() == 0) begin
          report_error($sformatf("unexpected word %h last %b end %b",
                                 out_tdata, out_tlast, out_tuser));
        end else begin
          want_word = frame_words.pop_front();
          if (got_word !== want_word) begin
            report_error($sformatf("expected %h last %b end %b, got %h last %b end %b",
                                   want_word.fbyte, want_word.run_last, want_word.frame_end,
                                   got_word.fbyte, got_word.run_last, got_word.frame_end));
          end
        end
      end
      if (pressure_arm && !pressure_done) begin
        hold_cnt      <= HOLD_CYCLES;
        pressure_done <= 1'b1;
        out_tready    <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] d;
    logic [7:0] c;
    int         roll;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset direction byte, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(stim_tab[i].data, stim_tab[i].count, stim_tab[i].n_typed,
                stim_tab[i].typed_bytes);
    end

    // Random phases; the first write lands while the long frame is still open
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       write_dir(8'h00);
        1:       write_dir(8'hFF);
        default: write_dir(8'($urandom_range(0, 255)));
      endcase
      gap_pct    = (ph == 1) ? 45 : (ph == 3) ? 19 : 0;
      stall_pct <= (ph == 2) ? 45 : (ph == 3) ? 19 : 0;
      if (ph == 0) pressure_arm <= 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)      d = 8'h00;
        else if (roll < 20) d = 8'hFF;
        else                d = 8'($urandom_range(0, 255));

        // Count matters only when it opens a frame; keep frames short
        if (left_cnt != 8'd0) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 60)      c = 8'($urandom_range(1, 4));
          else if (roll < 85) c = 8'($urandom_range(5, 16));
          else if (roll < 93) c = 8'd0;
          else                c = 8'($urandom_range(17, 40));
        end
        send_word(d, c, 4'd0, 72'h0);
      end
    end

    // Wait for the last words, then watch for strays
    in_tvalid <= 1'b0;
    while (frame_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
